// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers included by the accumulator_cpu_step rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/acs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Types, opcodes and codes of the accumulator machine.
// ----------------------------------------------------------------------------
package acs_pkg;

	// memory geometry
	localparam int ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	typedef logic [15:0]          word_t;
	typedef logic signed [15:0]   sword_t;
	typedef logic [ADDR_BITS-1:0] maddr_t;

	// transaction kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_EXEC = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// status codes, also used as fault codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_HALTED = 2'd1;
	localparam logic [1:0] STAT_DIVZ   = 2'd2;
	localparam logic [1:0] STAT_BADOP  = 2'd3;

	// opcodes
	localparam word_t OP_ADD  = 16'd1;
	localparam word_t OP_SUB  = 16'd2;
	localparam word_t OP_MUL  = 16'd3;
	localparam word_t OP_DIV  = 16'd4;
	localparam word_t OP_JMP  = 16'd5;
	localparam word_t OP_JNEG = 16'd6;
	localparam word_t OP_JPOS = 16'd7;
	localparam word_t OP_JZER = 16'd8;
	localparam word_t OP_CPY  = 16'd9;
	localparam word_t OP_LDA  = 16'd10;
	localparam word_t OP_STA  = 16'd11;
	localparam word_t OP_INP  = 16'd12;
	localparam word_t OP_OUT  = 16'd13;
	localparam word_t OP_HALT = 16'd14;

	// divider step count
	localparam int DIV_STEPS = 16;

	// sequencer states
	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_LOAD   = 14'b00000000000100,
		S_RD     = 14'b00000000001000,
		S_F0     = 14'b00000000010000,
		S_F1     = 14'b00000000100000,
		S_F2     = 14'b00000001000000,
		S_F3     = 14'b00000010000000,
		S_EX     = 14'b00000100000000,
		S_DIV    = 14'b00001000000000,
		S_DIVEND = 14'b00010000000000,
		S_WR     = 14'b00100000000000,
		S_STAT   = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

endpackage

// ===== rtl/acs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-port RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read at one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// 16-bit accumulator machine with a single-port word memory. After reset the
// block clears the whole memory, one word a cycle, with busy high.
// A transaction is taken when start is high and busy low; its result shows on
// the result ports for one cycle with done high, and the receiver cannot hold
// it off. Busy falls in that same cycle so a new start can be taken there. A
// load or a read passes through its memory access state, the unused kind goes
// straight to the status states, and an instruction passes the fetch states
// and the execute state; copy, store and input add a memory write state, and
// divide adds the divider states. This sequence is set by the single memory
// port (opcode, two operands, data word, write and the halt check of the next
// word are separate accesses) and by the 16-step shift-subtract divider.
// ----------------------------------------------------------------------------
module accumulator_cpu_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [1:0]     kind,
	input  acs_pkg::word_t  address,
	input  acs_pkg::word_t  load_word,
	input  acs_pkg::sword_t input_value,
	output logic           done,
	output logic [1:0]     status,
	output acs_pkg::word_t  read_word,
	output logic           out_valid,
	output acs_pkg::sword_t out_value,
	output logic           input_used,
	output acs_pkg::word_t  pc_now,
	output acs_pkg::sword_t acc_now
);

	import acs_pkg::*;

	state_t        state_q, state_d;
	maddr_t        clr_q;
	word_t         pc_q;
	word_t         acc_q;
	logic [1:0]    fault_q;
	logic          done_q;
	logic [1:0]    stat_q;

	logic [1:0]    kind_q;
	maddr_t        addr_q;
	word_t         lw_q;
	word_t         inval_q;
	word_t         op_q;
	word_t         opnd_q;
	word_t         opnd2_q;
	maddr_t        wr_addr_q;
	word_t         wr_data_q;
	word_t         read_q;
	logic          outv_q;
	word_t         outval_q;
	logic          inused_q;

	// divider registers
	word_t         den_q;
	word_t         quo_q;
	word_t         rem_q;
	logic          neg_q;
	logic [$clog2(DIV_STEPS)-1:0] div_cnt_q;

	// memory port
	logic          mem_we;
	maddr_t        mem_addr;
	word_t         mem_wdata;
	word_t         mem_rdata;

	word_t         pc_p1, pc_p2, pc_p3;
	word_t         prod;
	word_t         acc_mag, rd_mag;
	logic [16:0]   rem_sh, rem_diff;
	logic          acc_neg, acc_pos, acc_zero;

	acs_ram #(
		.WIDTH(16),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// shared arithmetic
	assign pc_p1    = pc_q + 16'd1;
	assign pc_p2    = pc_q + 16'd2;
	assign pc_p3    = pc_q + 16'd3;
	assign prod     = acc_q * mem_rdata;
	assign acc_mag  = acc_q[15] ? (16'd0 - acc_q) : acc_q;
	assign rd_mag   = mem_rdata[15] ? (16'd0 - mem_rdata) : mem_rdata;
	assign rem_sh   = {rem_q, quo_q[15]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign acc_neg  = acc_q[15];
	assign acc_zero = (acc_q == 16'd0);
	assign acc_pos  = !acc_neg && !acc_zero;

	// memory address and write select
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pc_q[ADDR_BITS-1:0];
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_LOAD: begin
				mem_we    = 1'b1;
				mem_addr  = addr_q;
				mem_wdata = lw_q;
			end
			S_RD:    mem_addr = addr_q;
			S_F0:    mem_addr = pc_q[ADDR_BITS-1:0];
			S_F1:    mem_addr = pc_p1[ADDR_BITS-1:0];
			S_F2:    mem_addr = pc_p2[ADDR_BITS-1:0];
			S_F3:    mem_addr = opnd_q[ADDR_BITS-1:0];
			S_WR: begin
				mem_we    = 1'b1;
				mem_addr  = wr_addr_q;
				mem_wdata = wr_data_q;
			end
			default: mem_addr = pc_q[ADDR_BITS-1:0];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_LOAD: state_d = S_LOAD;
						KIND_EXEC: state_d = S_F0;
						KIND_READ: state_d = S_RD;
						default:   state_d = S_STAT;
					endcase
				end
			end
			S_LOAD:   state_d = S_STAT;
			S_RD:     state_d = S_STAT;
			S_F0:     state_d = S_F1;
			S_F1:     state_d = S_F2;
			S_F2:     state_d = S_F3;
			S_F3:     state_d = S_EX;
			S_EX: begin
				state_d = S_STAT;
				if (fault_q == STAT_OK && op_q != OP_HALT) begin
					case (op_q)
						OP_DIV: if (mem_rdata != 16'd0) state_d = S_DIV;
						OP_CPY, OP_STA, OP_INP: state_d = S_WR;
						default: state_d = S_STAT;
					endcase
				end
			end
			S_DIV:    if (div_cnt_q == '0) state_d = S_DIVEND;
			S_DIVEND: state_d = S_STAT;
			S_WR:     state_d = S_STAT;
			S_STAT:   state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// architectural state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			acc_q   <= '0;
			fault_q <= STAT_OK;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + maddr_t'(1);
			end
			// execute one instruction
			if (state_q == S_EX && fault_q == STAT_OK && op_q != OP_HALT) begin
				case (op_q)
					OP_ADD: begin
						acc_q <= acc_q + mem_rdata;
						pc_q  <= pc_p2;
					end
					OP_SUB: begin
						acc_q <= acc_q - mem_rdata;
						pc_q  <= pc_p2;
					end
					OP_MUL: begin
						acc_q <= prod;
						pc_q  <= pc_p2;
					end
					OP_DIV: if (mem_rdata == 16'd0) fault_q <= STAT_DIVZ;
					OP_JMP:  pc_q <= opnd_q;
					OP_JNEG: pc_q <= acc_neg ? opnd_q : pc_p2;
					OP_JPOS: pc_q <= acc_pos ? opnd_q : pc_p2;
					OP_JZER: pc_q <= acc_zero ? opnd_q : pc_p2;
					OP_CPY:  pc_q <= pc_p3;
					OP_LDA: begin
						acc_q <= mem_rdata;
						pc_q  <= pc_p2;
					end
					OP_STA, OP_INP, OP_OUT: pc_q <= pc_p2;
					default: fault_q <= STAT_BADOP;
				endcase
			end
			// divide result
			if (state_q == S_DIVEND) begin
				acc_q <= neg_q ? (16'd0 - quo_q) : quo_q;
				pc_q  <= pc_p2;
			end
		end
	end

	// transaction payload, fetch, divider, write and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q   <= kind;
					addr_q   <= address[ADDR_BITS-1:0];
					lw_q     <= load_word;
					inval_q  <= input_value;
					read_q   <= '0;
					outv_q   <= 1'b0;
					outval_q <= '0;
					inused_q <= 1'b0;
				end
			end
			S_F1: op_q    <= mem_rdata;
			S_F2: opnd_q  <= mem_rdata;
			S_F3: opnd2_q <= mem_rdata;
			S_EX: begin
				if (fault_q == STAT_OK && op_q != OP_HALT) begin
					case (op_q)
						OP_DIV: begin
							den_q     <= rd_mag;
							quo_q     <= acc_mag;
							rem_q     <= '0;
							neg_q     <= acc_q[15] ^ mem_rdata[15];
							div_cnt_q <= $bits(div_cnt_q)'(DIV_STEPS - 1);
						end
						OP_CPY: begin
							wr_addr_q <= opnd2_q[ADDR_BITS-1:0];
							wr_data_q <= mem_rdata;
						end
						OP_STA: begin
							wr_addr_q <= opnd_q[ADDR_BITS-1:0];
							wr_data_q <= acc_q;
						end
						OP_INP: begin
							wr_addr_q <= opnd_q[ADDR_BITS-1:0];
							wr_data_q <= inval_q;
							inused_q  <= 1'b1;
						end
						OP_OUT: begin
							outv_q   <= 1'b1;
							outval_q <= mem_rdata;
						end
						default: ;
					endcase
				end
			end
			// one shift-subtract step per cycle
			S_DIV: begin
				if (!rem_diff[16]) begin
					rem_q <= rem_diff[15:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem_sh[15:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - $bits(div_cnt_q)'(1);
			end
			S_STAT: if (kind_q == KIND_READ) read_q <= mem_rdata;
			// status after the transaction
			S_DONE: begin
				if (fault_q != STAT_OK) begin
					stat_q <= fault_q;
				end else if (mem_rdata == OP_HALT) begin
					stat_q <= STAT_HALTED;
				end else begin
					stat_q <= STAT_OK;
				end
			end
			default: ;
		endcase
	end

	// result ports
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = stat_q;
	assign read_word  = read_q;
	assign out_valid  = outv_q;
	assign out_value  = outval_q;
	assign input_used = inused_q;
	assign pc_now     = pc_q;
	assign acc_now    = acc_q;

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !done, "no busy after start")
	`ASSERT_CLK(a_we_state, mem_we |-> (state_q == S_CLEAR || state_q == S_LOAD || state_q == S_WR), "stray memory write")
	`ASSERT_NEXT(a_fault_sticky, fault_q != STAT_OK, fault_q == $past(fault_q), "fault code changed")
	`ASSERT_CLK(a_one_effect, done |-> !(out_valid && input_used), "output and input in one step")
	`ASSERT_NEXT(a_div_exit, state_q == S_DIV && div_cnt_q == '0, state_q == S_DIVEND, "divider overrun")

endmodule
